FILE: rtl/core/aligned_stack_allocator_core_assert.svh
// Assertion macros for the aligned stack allocator checker.
// Needs clk and rst in the scope where the macros are used.
`ifndef ALIGNED_STACK_ALLOCATOR_CORE_ASSERT_SVH
`define ALIGNED_STACK_ALLOCATOR_CORE_ASSERT_SVH

// checked outside reset
`define ASA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define ASA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/asa_pkg.sv
// Package for the aligned stack allocator: sizes, codes and transaction types.
// No dependencies.
package asa_pkg;

  localparam int OFF_W          = 21;
  localparam int SUM_W          = OFF_W + 1;
  localparam int NE_W           = OFF_W + 2;
  localparam int MAX_LIVE       = 64;
  localparam int LIVE_W         = $clog2(MAX_LIVE + 1);
  localparam int ADDR_W         = $clog2(MAX_LIVE);
  localparam int HEADER_BYTES   = 16;
  localparam int HEADER_ALIGN   = 8;
  localparam int MAX_ALIGN_LOG2 = 6;
  localparam int ALIGN_W        = 3;
  localparam int MASK_W         = MAX_ALIGN_LOG2;

  localparam logic [OFF_W-1:0] CAP_MAX = OFF_W'(1048576);

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_RESIZE = 2'd2,
    KIND_RESET  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_ROOM = 3'd1,
    ST_NOT_TOP = 3'd2,
    ST_NULL    = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_RESIZE = 3'd2,
    OP_KEEP   = 3'd3,
    OP_NULL   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef struct packed {
    kind_t              kind;
    logic [OFF_W-1:0]   request_size;
    logic [OFF_W-1:0]   previous_size;
    logic [ALIGN_W-1:0] align_log2;
    logic [OFF_W-1:0]   block_offset;
    logic               block_present;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    logic             result_valid;
    status_t          status;
  } res_t;

  typedef struct packed {
    op_t               op;
    logic [OFF_W-1:0]  request_size;
    logic [OFF_W-1:0]  previous_size;
    logic [OFF_W-1:0]  block_offset;
    logic [MASK_W-1:0] amask;
  } cmd_t;

  typedef struct packed {
    logic    valid;
    cmd_t    cmd;
  } cmd_link_t;

  typedef struct packed {
    logic [OFF_W-1:0] prev_top;
    logic [OFF_W-1:0] start;
  } hdr_t;

endpackage

FILE: rtl/core/asa_front.sv
// Front end: accepts request transactions, classifies them into commands
// and holds them in a two-entry queue for the back end. Uses asa_pkg.
module asa_front import asa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output cmd_link_t cmd_link,
  input  logic      cmd_pop
);

  logic [ALIGN_W-1:0] alog_sat;
  cmd_t               dec;
  cmd_t               q [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    alog_sat = (item.align_log2 > ALIGN_W'(MAX_ALIGN_LOG2)) ?
               ALIGN_W'(MAX_ALIGN_LOG2) : item.align_log2;
    dec.request_size  = item.request_size;
    dec.previous_size = item.previous_size;
    dec.block_offset  = item.block_offset;
    dec.amask         = ~({MASK_W{1'b1}} << alog_sat);
    dec.op            = OP_CLEAR;
    unique case (item.kind)
      KIND_ALLOC: begin
        dec.op = OP_ALLOC;
      end
      KIND_FREE: begin
        dec.op = item.block_present ? OP_FREE : OP_NULL;
      end
      KIND_RESIZE: begin
        if (!item.block_present) begin
          dec.op = OP_NULL;
        end else if (item.request_size == item.previous_size) begin
          dec.op = OP_KEEP;
        end else if (item.request_size == '0) begin
          dec.op = OP_FREE;
        end else begin
          dec.op = OP_RESIZE;
        end
      end
      KIND_RESET: begin
        dec.op = OP_CLEAR;
      end
    endcase
  end

  assign full           = (count == 2'd2);
  assign do_push        = push && !full;
  assign do_pop         = cmd_pop && (count != 2'd0);
  assign cmd_link.valid = (count != 2'd0);
  assign cmd_link.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: rtl/core/asa_back.sv
// Back end: header memory, top offset, live count and capacity register.
// Reads the top header, then checks and commits one command. Uses asa_pkg.
module asa_back import asa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [OFF_W-1:0] cfg_wr_data,
  input  cmd_link_t        cmd_link,
  output logic             cmd_pop,
  output logic             res_push,
  output res_t             res,
  input  logic             res_full
);

  typedef enum logic [1:0] {
    S_TAKE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                  state;
  logic [OFF_W-1:0]        top_offset;
  logic [OFF_W-1:0]        top_next;
  logic [LIVE_W-1:0]       live_count;
  logic [LIVE_W-1:0]       live_next;
  logic [OFF_W-1:0]        capacity;
  cmd_t                    cur;
  hdr_t                    rd_hdr;
  hdr_t                    mem [MAX_LIVE];
  logic [SUM_W-1:0]        start_q;
  logic signed [NE_W-1:0]  new_end_q;
  logic [SUM_W-1:0]        hdr_pos;
  logic [SUM_W-1:0]        blk_start;
  logic signed [NE_W-1:0]  new_end;
  logic [NE_W-1:0]         alloc_end;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  hdr_t                    wr_data;
  logic                    mem_we;
  logic                    exec_go;
  logic                    is_top;
  logic                    ne_bad;

  assign cmd_pop  = (state == S_TAKE) && cmd_link.valid;
  assign exec_go  = (state == S_EXEC) && !res_full;
  assign res_push = exec_go;
  assign rd_addr  = ADDR_W'(live_count - LIVE_W'(1));
  assign wr_addr  = live_count[ADDR_W-1:0];

  // block placement and resize end, from the command at the queue head
  always_comb begin
    hdr_pos   = (SUM_W'(top_offset) + SUM_W'(HEADER_ALIGN - 1)) &
                ~SUM_W'(HEADER_ALIGN - 1);
    blk_start = (hdr_pos + SUM_W'(HEADER_BYTES) + SUM_W'(cmd_link.cmd.amask)) &
                ~SUM_W'(cmd_link.cmd.amask);
    new_end   = $signed({2'b00, top_offset}) -
                $signed({2'b00, cmd_link.cmd.previous_size}) +
                $signed({2'b00, cmd_link.cmd.request_size});
  end

  always_comb begin
    is_top    = (live_count != '0) && (rd_hdr.start == cur.block_offset);
    alloc_end = NE_W'(start_q) + NE_W'(cur.request_size);
    ne_bad    = (new_end_q > $signed({2'b00, capacity})) ||
                (new_end_q < $signed({2'b00, rd_hdr.start}));
    res.result_offset = '0;
    res.result_valid  = 1'b0;
    res.status        = ST_OK;
    top_next          = top_offset;
    live_next         = live_count;
    mem_we            = 1'b0;
    wr_data.prev_top  = top_offset;
    wr_data.start     = OFF_W'(start_q);
    unique case (cur.op)
      OP_ALLOC: begin
        if (live_count == LIVE_W'(MAX_LIVE)) begin
          res.status = ST_FULL;
        end else if (alloc_end > NE_W'(capacity)) begin
          res.status = ST_NO_ROOM;
        end else begin
          res.result_offset = OFF_W'(start_q);
          res.result_valid  = 1'b1;
          top_next          = OFF_W'(alloc_end);
          live_next         = live_count + LIVE_W'(1);
          mem_we            = exec_go;
        end
      end
      OP_FREE: begin
        if (!is_top) begin
          res.status = ST_NOT_TOP;
        end else begin
          top_next  = rd_hdr.prev_top;
          live_next = live_count - LIVE_W'(1);
        end
      end
      OP_RESIZE: begin
        if (!is_top) begin
          res.status = ST_NOT_TOP;
        end else if (ne_bad) begin
          res.status = ST_NO_ROOM;
        end else begin
          res.result_offset = cur.block_offset;
          res.result_valid  = 1'b1;
          top_next          = OFF_W'(new_end_q);
        end
      end
      OP_KEEP: begin
        res.result_offset = cur.block_offset;
        res.result_valid  = 1'b1;
      end
      OP_NULL: begin
        res.status = ST_NULL;
      end
      OP_CLEAR: begin
        top_next  = '0;
        live_next = '0;
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_pop) begin
      rd_hdr    <= mem[rd_addr];
      cur       <= cmd_link.cmd;
      start_q   <= blk_start;
      new_end_q <= new_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_TAKE;
      top_offset <= '0;
      live_count <= '0;
      capacity   <= CAP_MAX;
    end else begin
      if (cfg_wr_en) begin
        capacity <= (cfg_wr_data > CAP_MAX) ? CAP_MAX : cfg_wr_data;
      end
      unique case (state)
        S_TAKE: begin
          if (cmd_pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            top_offset <= top_next;
            live_count <= live_next;
            state      <= S_TAKE;
          end
        end
        default: begin
          state <= S_TAKE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/asa_res_queue.sv
// Two-entry result queue between the back end and the result port.
// Uses asa_pkg for the result transaction type.
module asa_res_queue import asa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t data,
  output logic full,
  output logic empty,
  input  logic pop,
  output res_t head
);

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: rtl/core/aligned_stack_allocator_core.sv
// An accepted request is taken by the back end, which registers the command and reads
// the top header from its memory, then checks and commits it, holding while the result
// queue is full; the back end takes no new command until the last one is committed.
// Reset (synchronous): top offset and live count cleared, capacity back to 1 MiB,
// both queues emptied; the header memory is not cleared.
module aligned_stack_allocator_core import asa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [OFF_W-1:0] cfg_wr_data,
  input  logic             push,
  output logic             full,
  input  in_item_t         item,
  output logic             empty,
  input  logic             pop,
  output res_t             result
);

  cmd_link_t cmd_link;
  logic      cmd_pop;
  logic      res_push;
  res_t      res;
  logic      res_full;

  asa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_link (cmd_link),
    .cmd_pop  (cmd_pop)
  );

  asa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_link    (cmd_link),
    .cmd_pop     (cmd_pop),
    .res_push    (res_push),
    .res         (res),
    .res_full    (res_full)
  );

  asa_res_queue u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .data  (res),
    .full  (res_full),
    .empty (empty),
    .pop   (pop),
    .head  (result)
  );

endmodule

FILE: rtl/core/asa_checker.sv
// Port-level checker for aligned_stack_allocator_core, bound to the top level.
// Uses asa_pkg and the macros in aligned_stack_allocator_core_assert.svh.
`include "aligned_stack_allocator_core_assert.svh"

module asa_checker import asa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input res_t result
);

  // no result can come out right after reset, before a first request has passed the front queue and the back end
  `ASA_ASSERT_RST(a_quiet_after_rst, rst |=> empty ##1 empty ##1 empty, "result too early after reset")

  // the request queue only fills through accepted transactions
  `ASA_ASSERT(a_full_needs_push, (!full && !push) |=> !full, "full rose without a push")

  // a waiting result stays put until it is taken
  `ASA_ASSERT(a_result_held, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")

endmodule

bind aligned_stack_allocator_core asa_checker u_asa_checker (.*);

FILE: verif/tb_aligned_stack_allocator_core.sv
// Self-checking bench for aligned_stack_allocator_core: directed and random alloc, free,
// resize and clear transactions, with every reply checked against a stack model held here.
// Depends on asa_pkg and the core RTL.
module tb_aligned_stack_allocator_core;
  import asa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [OFF_W-1:0]                cap;
    logic [OFF_W-1:0]                top;
    logic [LIVE_W-1:0]               live;
    logic [MAX_LIVE-1:0][OFF_W-1:0]  hprev;
    logic [MAX_LIVE-1:0][OFF_W-1:0]  hstart;
  } heap_state_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [OFF_W-1:0] cfg_wr_data = '0;
  logic             push = 1'b0;
  logic             full;
  in_item_t         item = '0;
  logic             empty;
  logic             pop = 1'b0;
  res_t             result;

  heap_state_t model_st;
  heap_state_t plan_st;
  in_item_t    request_q[$];
  res_t        reply_q[$];
  bit          req_taken = 1'b0;
  int          in_idle_pct = 10;
  int          out_idle_pct = 10;
  int          planned = 0;
  int          accepted = 0;
  int          checked = 0;
  int          err_count = 0;
  int          cap_writes = 0;
  int          cycle_count = 0;
  int          outcome_seen[5] = '{default: 0};

  aligned_stack_allocator_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

  always #6 clk = ~clk;

  function automatic heap_state_t fresh_heap();
    heap_state_t s;
    s = '0;
    s.cap = CAP_MAX;
    return s;
  endfunction

  function automatic res_t mk_res(logic [OFF_W-1:0] off, logic v, status_t st);
    res_t r;
    r.result_offset = off;
    r.result_valid  = v;
    r.status        = st;
    return r;
  endfunction

  function automatic bit is_top(heap_state_t s, logic [OFF_W-1:0] off);
    return s.live > 0 && s.hstart[s.live - 1] == off;
  endfunction

  function automatic res_t pop_block(inout heap_state_t s, input logic [OFF_W-1:0] off);
    if (!is_top(s, off)) return mk_res('0, 1'b0, ST_NOT_TOP);
    s.top = s.hprev[s.live - 1];
    s.live--;
    return mk_res('0, 1'b0, ST_OK);
  endfunction

  function automatic res_t heap_reply(inout heap_state_t s, input in_item_t it);
    longint unsigned base, hdr, amt, start, fin;
    longint          new_end;
    int unsigned     alog;
    case (it.kind)
      KIND_ALLOC: begin
        alog = (it.align_log2 > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : it.align_log2;
        amt = 64'd1 << alog;
        if (s.live >= MAX_LIVE) return mk_res('0, 1'b0, ST_FULL);
        base = s.top;
        hdr = ((base + HEADER_ALIGN - 1) / HEADER_ALIGN) * HEADER_ALIGN;
        start = ((hdr + HEADER_BYTES + amt - 1) / amt) * amt;
        fin = start + it.request_size;
        if (fin > s.cap) return mk_res('0, 1'b0, ST_NO_ROOM);
        s.hprev[s.live]  = s.top;
        s.hstart[s.live] = start[OFF_W-1:0];
        s.live++;
        s.top = fin[OFF_W-1:0];
        return mk_res(start[OFF_W-1:0], 1'b1, ST_OK);
      end
      KIND_FREE: begin
        if (!it.block_present) return mk_res('0, 1'b0, ST_NULL);
        return pop_block(s, it.block_offset);
      end
      KIND_RESIZE: begin
        if (!it.block_present) return mk_res('0, 1'b0, ST_NULL);
        if (it.request_size == it.previous_size) return mk_res(it.block_offset, 1'b1, ST_OK);
        if (it.request_size == '0) return pop_block(s, it.block_offset);
        if (!is_top(s, it.block_offset)) return mk_res('0, 1'b0, ST_NOT_TOP);
        new_end = longint'(s.top) - longint'(it.previous_size) + longint'(it.request_size);
        if (new_end > longint'(s.cap) || new_end < longint'(s.hstart[s.live - 1]))
          return mk_res('0, 1'b0, ST_NO_ROOM);
        s.top = new_end[OFF_W-1:0];
        return mk_res(it.block_offset, 1'b1, ST_OK);
      end
      default: begin
        s.top  = '0;
        s.live = '0;
        return mk_res('0, 1'b0, ST_OK);
      end
    endcase
  endfunction

  function automatic in_item_t mk_item(kind_t k, logic [OFF_W-1:0] req,
                                       logic [OFF_W-1:0] prev, logic [ALIGN_W-1:0] alog,
                                       logic [OFF_W-1:0] off, logic present);
    in_item_t it;
    it.kind          = k;
    it.request_size  = req;
    it.previous_size = prev;
    it.align_log2    = alog;
    it.block_offset  = off;
    it.block_present = present;
    return it;
  endfunction

  function automatic logic [OFF_W-1:0] top_start();
    return (plan_st.live > 0) ? plan_st.hstart[plan_st.live - 1] : '0;
  endfunction

  function automatic logic [OFF_W-1:0] top_size();
    return plan_st.top - top_start();
  endfunction

  task automatic plan(in_item_t it);
    void'(heap_reply(plan_st, it));
    request_q.push_back(it);
    planned++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (accepted != planned || reply_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_capacity(logic [OFF_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_st.cap = (v > CAP_MAX) ? CAP_MAX : v;
    plan_st.cap  = model_st.cap;
    cap_writes++;
  endtask

  // mostly well-formed traffic on the top block, the rest broken or null requests
  task automatic random_phase(int n, int alloc_pct, int size_max, int clear_pct);
    in_item_t         it;
    logic [OFF_W-1:0] ts, sz;
    int               r;
    for (int i = 0; i < n; i++) begin
      it = mk_item(kind_t'($urandom_range(3)), OFF_W'($urandom()), OFF_W'($urandom()),
                   ALIGN_W'($urandom_range(7)), OFF_W'($urandom()), 1'($urandom_range(1)));
      ts = top_start();
      sz = top_size();
      r = $urandom_range(99);
      if (r < clear_pct) begin
        it.kind = KIND_RESET;
      end else if (r < clear_pct + alloc_pct) begin
        it.kind = KIND_ALLOC;
        if ($urandom_range(49) != 0) it.request_size = OFF_W'($urandom_range(size_max));
      end else if (r < 90) begin
        it.block_present = 1'b1;
        it.block_offset  = ts;
        if ($urandom_range(1)) begin
          it.kind = KIND_FREE;
        end else begin
          it.kind = KIND_RESIZE;
          it.previous_size = sz;
          case ($urandom_range(7))
            0: it.request_size = '0;
            1: it.request_size = sz;
            2: ;
            3: begin
              it.previous_size = sz + OFF_W'($urandom_range(1, 64));
              it.request_size  = OFF_W'($urandom_range(1, 32));
            end
            default: it.request_size = OFF_W'($urandom_range(size_max));
          endcase
        end
      end else begin
        it.kind = $urandom_range(1) ? KIND_FREE : KIND_RESIZE;
        if ($urandom_range(1)) it.block_offset = ts ^ (OFF_W'(1) << $urandom_range(OFF_W - 1));
        if ($urandom_range(1)) it.request_size = OFF_W'($urandom_range(size_max));
      end
      plan(it);
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || req_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          item <= request_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin : mon
    res_t want;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (pop && !empty) begin
        if (reply_q.size() == 0) begin
          $error("reply popped with no transaction outstanding");
          err_count++;
        end else begin
          want = reply_q.pop_front();
          checked++;
          outcome_seen[int'(want.status)]++;
          if (result.result_offset !== want.result_offset) begin
            $error("result_offset: expected %0d, got %0d", want.result_offset,
                   result.result_offset);
            err_count++;
          end
          if (result.result_valid !== want.result_valid) begin
            $error("result_valid: expected %0d, got %0d", want.result_valid,
                   result.result_valid);
            err_count++;
          end
          if (result.status !== want.status) begin
            $error("status field: expected %0d, got %0d", want.status, result.status);
            err_count++;
          end
        end
      end
      req_taken = push && !full;
      if (req_taken) begin
        reply_q.push_back(heap_reply(model_st, item));
        accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    model_st = fresh_heap();
    plan_st  = fresh_heap();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan(mk_item(KIND_ALLOC, '0, '0, '0, '0, 1'b0));
    plan(mk_item(KIND_ALLOC, OFF_W'(1), '0, ALIGN_W'(7), '0, 1'b0));
    for (int a = 1; a <= 6; a++)
      plan(mk_item(KIND_ALLOC, OFF_W'(a * 3), '0, ALIGN_W'(a), '0, 1'b0));
    plan(mk_item(KIND_FREE, '0, '0, '0, top_start(), 1'b0));
    plan(mk_item(KIND_RESIZE, OFF_W'(8), OFF_W'(4), '0, top_start(), 1'b0));
    plan(mk_item(KIND_FREE, '0, '0, '0, top_start() + OFF_W'(1), 1'b1));
    plan(mk_item(KIND_RESIZE, OFF_W'(5), OFF_W'(5), '0, 21'h1FFFFF, 1'b1));
    plan(mk_item(KIND_RESIZE, top_size() + OFF_W'(100), top_size(), '0, top_start(), 1'b1));
    plan(mk_item(KIND_RESIZE, OFF_W'(1), top_size() + OFF_W'(50), '0, top_start(), 1'b1));
    plan(mk_item(KIND_RESIZE, 21'h1FFFFF, top_size(), '0, top_start(), 1'b1));
    plan(mk_item(KIND_RESIZE, '0, OFF_W'(7), '0, top_start() - OFF_W'(8), 1'b1));
    plan(mk_item(KIND_RESIZE, '0, top_size(), '0, top_start(), 1'b1));
    plan(mk_item(KIND_FREE, '0, '0, '0, top_start(), 1'b1));
    plan(mk_item(KIND_ALLOC, CAP_MAX, '0, '0, '0, 1'b0));
    plan(mk_item(KIND_RESET, '0, '0, '0, '0, 1'b0));
    plan(mk_item(KIND_FREE, '0, '0, '0, '0, 1'b1));
    plan(mk_item(KIND_ALLOC, CAP_MAX - OFF_W'(HEADER_BYTES), '0, '0, '0, 1'b0));
    plan(mk_item(KIND_ALLOC, '0, '0, '0, '0, 1'b0));
    plan(mk_item(KIND_FREE, '0, '0, '0, top_start(), 1'b1));
    drain();

    random_phase(400, 45, 300, 2);
    set_capacity('0);
    random_phase(20, 50, 64, 0);
    set_capacity(21'h1FFFFF);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_phase(350, 65, 64, 0);
    drain();
    in_idle_pct  = 10;
    out_idle_pct = 10;
    set_capacity(OFF_W'(4096));
    random_phase(300, 45, 600, 3);
    set_capacity(CAP_MAX);
    random_phase(300, 50, 65535, 2);
    set_capacity(CAP_MAX - OFF_W'(1));
    random_phase(280, 45, 2000, 2);
    drain();
    repeat (8) @(posedge clk);

    $display("%0d requests over %0d capacity settings, %0d replies checked",
             accepted, cap_writes + 1, checked);
    $display("outcomes: ok %0d, no room %0d, not top %0d, null %0d, stack full %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/asa_pkg.sv
rtl/core/asa_front.sv
rtl/core/asa_back.sv
rtl/core/asa_res_queue.sv
rtl/core/aligned_stack_allocator_core.sv
rtl/core/asa_checker.sv
verif/tb_aligned_stack_allocator_core.sv
